>>> rtl/sbus_frame_decoder_top_assert.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef SBUS_FRAME_DECODER_TOP_ASSERT_SVH
`define SBUS_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbfd assertion failed");

// next-cycle implication, checked outside reset
`define SBFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbfd assertion failed");

`endif

>>> rtl/sbfd_pkg.sv
// Types, constants and helpers shared by the frame decoder modules.
package sbfd_pkg;

   localparam int FRAME_BYTES  = 25;
   localparam int LAST_POS     = FRAME_BYTES - 1;
   localparam int POS_BITS     = 5;
   localparam int STREAM_BYTES = FRAME_BYTES - 2;
   localparam int STREAM_BITS  = STREAM_BYTES * 8;
   localparam int CH_BITS      = 11;
   localparam int CH_IDX_BITS  = 4;
   localparam int CNT_BITS     = 32;
   localparam int REQ_BITS     = 40;
   localparam int RSP_BITS     = 152;
   localparam int QUEUE_DEPTH  = 2;
   localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] START_BYTE = 8'h0F;
   localparam logic [7:0] END_BYTE   = 8'h00;
   localparam logic [3:0] END_NIBBLE = 4'h4;

   localparam logic [CH_BITS-1:0] CLAMP_MIN_RST  = 11'd172;
   localparam logic [CH_BITS-1:0] CLAMP_MAX_RST  = 11'd1811;
   localparam logic [CH_BITS-1:0] LOW_LIMIT_RST  = 11'd600;
   localparam logic [CH_BITS-1:0] HIGH_LIMIT_RST = 11'd1400;

   typedef enum logic [1:0] {
      REG_CLAMP_MIN,
      REG_CLAMP_MAX,
      REG_LOW_LIMIT,
      REG_HIGH_LIMIT
   } sbfd_reg_type;

   // one good frame, handed from front to back
   typedef struct packed {
      logic [STREAM_BITS-1:0] stream;
      logic                   failsafe;
      logic                   frame_lost;
      logic [CNT_BITS-1:0]    lost_count;
      logic [CNT_BITS-1:0]    skipped_count;
      logic [CNT_BITS-1:0]    error_count;
      logic [CNT_BITS-1:0]    period_us;
   } sbfd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sbfd_qstat_type;

   function automatic logic is_end_type(input logic [7:0] b);
      return (b == END_BYTE) || (b[3:0] == END_NIBBLE);
   endfunction

endpackage

>>> rtl/sbfd_front.sv
// Front end: byte sync, frame collection, end check, event counters.
`include "sbus_frame_decoder_top_assert.svh"
module sbfd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              rx_byte,
   input  logic [31:0]             time_us,
   input  sbfd_pkg::sbfd_qstat_type q_stat,
   output logic                    push,
   output sbfd_pkg::sbfd_entry_type push_entry
);
   import sbfd_pkg::*;

   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [7:0]             prev_ff, prev_in;
   logic [STREAM_BITS-1:0] stream_ff, stream_in;
   logic [CNT_BITS-1:0]    lost_ff, lost_in;
   logic [CNT_BITS-1:0]    skip_ff, skip_in;
   logic [CNT_BITS-1:0]    err_ff, err_in;
   logic [CNT_BITS-1:0]    time_ff, time_in;
   logic                   req_fire;
   logic                   at_end;
   logic [7:0]             flags;

   assign at_end     = (pos_ff == POS_BITS'(LAST_POS));
   // only the end byte needs room in the queue
   assign req_tready = !(at_end && q_stat.full);
   assign req_fire   = req_tvalid && req_tready;
   assign flags      = stream_ff[STREAM_BITS-1 -: 8];

   always_comb begin
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      stream_in = stream_ff;
      lost_in   = lost_ff;
      skip_in   = skip_ff;
      err_in    = err_ff;
      time_in   = time_ff;
      push      = 1'b0;
      if (req_fire) begin
         prev_in = rx_byte;
         priority if (pos_ff == '0) begin
            if (rx_byte == START_BYTE && is_end_type(prev_ff)) begin
               pos_in = POS_BITS'(1);
            end else begin
               skip_in = skip_ff + 1'b1;
            end
         end else if (!at_end) begin
            stream_in = {rx_byte, stream_ff[STREAM_BITS-1:8]};
            pos_in    = pos_ff + 1'b1;
         end else begin
            pos_in = '0;
            if (is_end_type(rx_byte)) begin
               push    = 1'b1;
               lost_in = lost_ff + CNT_BITS'(flags[2]);
               time_in = time_us;
            end else begin
               err_in = err_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      push_entry.stream        = stream_ff;
      push_entry.failsafe      = flags[3];
      push_entry.frame_lost    = flags[2];
      push_entry.lost_count    = lost_in;
      push_entry.skipped_count = skip_ff;
      push_entry.error_count   = err_ff;
      push_entry.period_us     = time_us - time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         prev_ff <= END_BYTE;
         lost_ff <= '0;
         skip_ff <= '0;
         err_ff  <= '0;
         time_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         prev_ff <= prev_in;
         lost_ff <= lost_in;
         skip_ff <= skip_in;
         err_ff  <= err_in;
         time_ff <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      stream_ff <= stream_in;
   end

   `SBFD_ASSERT_NOW(a_push_at_end, clock, reset, push, at_end && req_fire)
   `SBFD_ASSERT_NOW(a_pos_range, clock, reset, 1'b1, pos_ff <= POS_BITS'(LAST_POS))

endmodule

>>> rtl/sbfd_queue.sv
// Two-entry frame queue between the front end and the channel emitter.
`include "sbus_frame_decoder_top_assert.svh"
module sbfd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sbfd_pkg::sbfd_entry_type push_entry,
   input  logic                     pop,
   output sbfd_pkg::sbfd_entry_type head,
   output sbfd_pkg::sbfd_qstat_type q_stat
);
   import sbfd_pkg::*;

   sbfd_entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ff, wr_in;
   logic [PTR_BITS-1:0]   rd_ff, rd_in;
   logic [PTR_BITS:0]     cnt_ff, cnt_in;

   assign q_stat.full  = (cnt_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head         = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PTR_BITS'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? PTR_BITS'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   `SBFD_ASSERT_NOW(a_no_overflow, clock, reset, push, !q_stat.full)
   `SBFD_ASSERT_NOW(a_no_underflow, clock, reset, pop, !q_stat.empty)

endmodule

>>> rtl/sbfd_back.sv
// Back end: per-channel unpack, clamp, classify, output register, limit registers.
`include "sbus_frame_decoder_top_assert.svh"
module sbfd_back #(
   parameter int NUM_CHANNELS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_index,
   input  logic [sbfd_pkg::CH_BITS-1:0]          csr_data,
   input  sbfd_pkg::sbfd_entry_type              head,
   input  sbfd_pkg::sbfd_qstat_type              q_stat,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sbfd_pkg::RSP_BITS-1:0]         rsp_tdata,
   output logic                                  rsp_tlast
);
   import sbfd_pkg::*;

   localparam logic [CH_IDX_BITS-1:0] LAST_CH = CH_IDX_BITS'(NUM_CHANNELS - 1);

   logic [CH_BITS-1:0]     cmin_ff, cmax_ff, low_ff, high_ff;
   logic [CH_IDX_BITS-1:0] ch_ff, ch_in;
   logic                   valid_ff, valid_in;
   logic [RSP_BITS-1:0]    data_ff, data_in;
   logic                   last_ff, last_in;
   logic                   load;
   logic                   emit;
   logic [7:0]             offset;
   logic [CH_BITS-1:0]     raw;
   logic [CH_BITS-1:0]     value;
   logic                   is_low, is_center, is_high;
   sbfd_reg_type           reg_sel;

   assign csr_ready = 1'b1;
   assign reg_sel   = sbfd_reg_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmin_ff <= CLAMP_MIN_RST;
         cmax_ff <= CLAMP_MAX_RST;
         low_ff  <= LOW_LIMIT_RST;
         high_ff <= HIGH_LIMIT_RST;
      end else if (csr_valid) begin
         unique case (reg_sel)
            REG_CLAMP_MIN:  cmin_ff <= csr_data;
            REG_CLAMP_MAX:  cmax_ff <= csr_data;
            REG_LOW_LIMIT:  low_ff  <= csr_data;
            REG_HIGH_LIMIT: high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign load = !valid_ff || rsp_tready;
   assign emit = load && !q_stat.empty;
   assign pop  = emit && (ch_ff == LAST_CH);

   assign offset = 8'(ch_ff) * 8'(CH_BITS);
   assign raw    = head.stream[offset +: CH_BITS];

   always_comb begin
      priority if (raw < cmin_ff) begin
         value = cmin_ff;
      end else if (raw > cmax_ff) begin
         value = cmax_ff;
      end else begin
         value = raw;
      end
      is_low    = value < low_ff;
      is_center = (low_ff < value) && (value < high_ff);
      is_high   = high_ff < value;
   end

   always_comb begin
      ch_in    = ch_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (emit) begin
         ch_in    = pop ? '0 : ch_ff + 1'b1;
         valid_in = 1'b1;
         last_in  = pop;
         data_in  = {4'b0, head.period_us, head.error_count, head.skipped_count,
                     head.lost_count, head.frame_lost, head.failsafe,
                     is_high, is_center, is_low, value, ch_ff};
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         ch_ff    <= ch_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   `SBFD_ASSERT_NOW(a_mid_frame_has_head, clock, reset, ch_ff != '0, !q_stat.empty)
   `SBFD_ASSERT_NEXT(a_pop_marks_last, clock, reset, pop, rsp_tvalid && rsp_tlast)

endmodule

>>> rtl/sbus_frame_decoder_top.sv
// Top level of the serial-bus frame decoder.
// Usage:
//   req_*  : one received serial byte and its microsecond timestamp per request.
//   rsp_*  : one result per channel of each good frame, channel 0 first; tlast
//            marks the final channel of the frame.
//   csr_*  : limit register writes (index 0..3: clamp_min, clamp_max, low_limit,
//            high_limit), always ready; write only while the decoder is idle.
// Throughput: one byte per cycle on the request side while req_tready is high;
//   one channel result per cycle on the result side while the receiver is
//   ready and a frame is queued. A good frame yields NUM_CHANNELS results.
// With the back end idle, the first result of a frame is valid once the end
//   byte is accepted, written into the queue and loaded into the output register.
// A two-frame queue separates byte intake from result emission. When the
//   receiver stalls, results wait in the output register and bytes keep flowing;
//   only the end byte of a frame is held off while the queue is full.
// Bad start or end bytes produce no result, they only advance the counters.
// Reset (synchronous, active high) clears position, counters, queue and output
//   valid, and restores the limit registers to their defaults.
module sbus_frame_decoder_top #(
   parameter int NUM_CHANNELS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [7:0] rx_byte, [39:8] time_us
   input  logic [sbfd_pkg::REQ_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [3:0] channel_index, [14:4] channel_value, [15] is_low, [16] is_center,
   // [17] is_high, [18] failsafe, [19] frame_lost, [51:20] lost_count,
   // [83:52] skipped_count, [115:84] error_count, [147:116] period_us, zero pad
   output logic [sbfd_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [sbfd_pkg::CH_BITS-1:0]  csr_data
);
   import sbfd_pkg::*;

   logic           push;
   logic           pop;
   sbfd_entry_type push_entry;
   sbfd_entry_type head;
   sbfd_qstat_type q_stat;

   sbfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rx_byte    (req_tdata[7:0]),
      .time_us    (req_tdata[39:8]),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   sbfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   sbfd_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/sbus_frame_decoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial-bus frame decoder top level.
module sbus_frame_decoder_top_tb;
   import sbfd_pkg::*;

   localparam int NUM_CH       = 10;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [3:0]  index;
      logic [10:0] value;
      logic        is_low;
      logic        is_center;
      logic        is_high;
      logic        last;
      logic        failsafe;
      logic        frame_lost;
      logic [31:0] lost_count;
      logic [31:0] skipped_count;
      logic [31:0] error_count;
      logic [31:0] period_us;
   } chan_result_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [CH_BITS-1:0]  csr_data;

   // decoder state as predicted by the testbench
   logic [4:0]  byte_pos;
   logic [7:0]  prev_byte;
   logic [7:0]  frame_bytes [24];
   logic [31:0] lost_frames;
   logic [31:0] skipped_starts;
   logic [31:0] bad_end_frames;
   logic [31:0] last_frame_us;
   logic [10:0] clamp_lo;
   logic [10:0] clamp_hi;
   logic [10:0] low_lim;
   logic [10:0] high_lim;

   chan_result_type chan_results_q [$];
   int              mismatch_count;
   int              req_gap_max;
   int              rsp_gap_max;
   int              rsp_hold;
   logic [31:0]     stamp_us;

   sbus_frame_decoder_top #(
      .NUM_CHANNELS(NUM_CH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

   function automatic logic ends_frame(input logic [7:0] b);
      return (b == END_BYTE) || (b[3:0] == END_NIBBLE);
   endfunction

   // Advances the predicted decoder by one accepted byte.
   function automatic void decode_serial_byte(input logic [7:0] b, input logic [31:0] t);
      logic [23:0]     window;
      logic [10:0]     v;
      int              bitpos;
      int              j;
      logic            fs;
      logic            lost;
      chan_result_type r;
      if (byte_pos == 0) begin
         if (b == START_BYTE && ends_frame(prev_byte)) begin
            frame_bytes[0] = b;
            byte_pos = 5'd1;
         end else begin
            skipped_starts++;
         end
      end else if (byte_pos < FRAME_BYTES - 1) begin
         frame_bytes[byte_pos] = b;
         byte_pos++;
      end else begin
         byte_pos = 5'd0;
         if (ends_frame(b)) begin
            fs   = frame_bytes[23][3];
            lost = frame_bytes[23][2];
            if (lost)
               lost_frames++;
            for (int ch = 0; ch < NUM_CH; ch++) begin
               bitpos = ch * 11;
               j      = 1 + bitpos / 8;
               window = {frame_bytes[(j + 2) % 24], frame_bytes[(j + 1) % 24],
                         frame_bytes[j % 24]};
               v = 11'(window >> (bitpos % 8));
               if (v < clamp_lo)
                  v = clamp_lo;
               else if (v > clamp_hi)
                  v = clamp_hi;
               r.index         = 4'(ch);
               r.value         = v;
               r.is_low        = v < low_lim;
               r.is_center     = (low_lim < v) && (v < high_lim);
               r.is_high       = high_lim < v;
               r.last          = ch == NUM_CH - 1;
               r.failsafe      = fs;
               r.frame_lost    = lost;
               r.lost_count    = lost_frames;
               r.skipped_count = skipped_starts;
               r.error_count   = bad_end_frames;
               r.period_us     = t - last_frame_us;
               chan_results_q.push_back(r);
            end
            last_frame_us = t;
         end else begin
            bad_end_frames++;
         end
      end
      prev_byte = b;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      chan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chan_results_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual channel %0d",
                     $time, rsp_tdata[3:0]);
            mismatch_count++;
         end else begin
            want = chan_results_q.pop_front();
            check_field("channel_index", want.index, rsp_tdata[3:0]);
            check_field("channel_value", want.value, rsp_tdata[14:4]);
            check_field("is_low", want.is_low, rsp_tdata[15]);
            check_field("is_center", want.is_center, rsp_tdata[16]);
            check_field("is_high", want.is_high, rsp_tdata[17]);
            check_field("last_channel", want.last, rsp_tlast);
            check_field("failsafe", want.failsafe, rsp_tdata[18]);
            check_field("frame_lost", want.frame_lost, rsp_tdata[19]);
            check_field("lost_count", want.lost_count, rsp_tdata[51:20]);
            check_field("skipped_count", want.skipped_count, rsp_tdata[83:52]);
            check_field("error_count", want.error_count, rsp_tdata[115:84]);
            check_field("period_us", want.period_us, rsp_tdata[147:116]);
         end
      end
   end

   // Result side: random stalls per result, plus a long hold on request.
   initial begin : rsp_drive
      int gap;
      rsp_tready = 1'b0;
      forever begin
         gap = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do
            @(posedge clock);
         while (!(rsp_tvalid && rsp_tready) && rsp_hold == 0);
         @(negedge clock);
      end
   end

   function automatic logic [31:0] next_stamp();
      if ($urandom_range(0, 39) == 0)
         stamp_us = $urandom;
      else
         stamp_us = stamp_us + $urandom_range(1, 300);
      return stamp_us;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
      int gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {t, b};
      do
         @(posedge clock);
      while (!req_tready);
      decode_serial_byte(b, t);
      @(negedge clock);
   endtask

   task automatic await_idle();
      req_tvalid <= 1'b0;
      while (chan_results_q.size() != 0)
         @(negedge clock);
      // a dropped frame leaves nothing to wait on, so cover the pipeline latency
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input sbfd_reg_type idx, input logic [10:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         REG_CLAMP_MIN:  clamp_lo = v;
         REG_CLAMP_MAX:  clamp_hi = v;
         REG_LOW_LIMIT:  low_lim = v;
         REG_HIGH_LIMIT: high_lim = v;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_limits(input logic [10:0] lo, input logic [10:0] hi,
                             input logic [10:0] low, input logic [10:0] high);
      await_idle();
      write_reg(REG_CLAMP_MIN, lo);
      write_reg(REG_CLAMP_MAX, hi);
      write_reg(REG_LOW_LIMIT, low);
      write_reg(REG_HIGH_LIMIT, high);
      csr_valid <= 1'b0;
   endtask

   // Channel values biased toward the configured boundaries.
   function automatic logic [10:0] pick_channel();
      case ($urandom_range(0, 7))
         0: return 11'd0;
         1: return 11'h7FF;
         2: return clamp_lo + 11'($urandom_range(0, 2)) - 11'd1;
         3: return clamp_hi + 11'($urandom_range(0, 2)) - 11'd1;
         4: return low_lim + 11'($urandom_range(0, 2)) - 11'd1;
         5: return high_lim + 11'($urandom_range(0, 2)) - 11'd1;
         default: return 11'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] end_type_byte();
      if ($urandom_range(0, 3) == 0)
         return END_BYTE;
      return {4'($urandom), END_NIBBLE};
   endfunction

   task automatic send_noise(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 2))
            0:       b = START_BYTE;
            1:       b = end_type_byte();
            default: b = 8'($urandom);
         endcase
         send_byte(b, next_stamp());
      end
   endtask

   task automatic send_frame(input bit good_end);
      logic [175:0] chans;
      logic [7:0]   end_byte;
      // finish any frame that noise opened, then make sure the start byte syncs
      while (byte_pos != 0)
         send_byte(8'($urandom), next_stamp());
      if (!ends_frame(prev_byte))
         send_byte(end_type_byte(), next_stamp());
      for (int ch = 0; ch < 16; ch++)
         chans[ch * 11 +: 11] = pick_channel();
      send_byte(START_BYTE, next_stamp());
      for (int i = 0; i < 22; i++)
         send_byte(chans[i * 8 +: 8], next_stamp());
      send_byte(8'($urandom), next_stamp());
      if (good_end) begin
         end_byte = end_type_byte();
      end else begin
         do
            end_byte = 8'($urandom);
         while (ends_frame(end_byte));
      end
      send_byte(end_byte, next_stamp());
   endtask

   task automatic send_fixed_frame(input logic [7:0] fill, input logic [7:0] flags,
                                   input logic [7:0] end_byte, input logic [31:0] end_us);
      send_byte(START_BYTE, next_stamp());
      for (int i = 0; i < 22; i++)
         send_byte(fill, next_stamp());
      send_byte(flags, next_stamp());
      send_byte(end_byte, end_us);
      stamp_us = end_us;
   endtask

   task automatic test_directed_frames();
      req_gap_max = 8;
      rsp_gap_max = 8;
      // hunting: plain byte, start not after an end byte, then an end-type byte
      send_byte(8'hFF, 32'h0);
      send_byte(START_BYTE, 32'h1);
      send_byte(8'h34, 32'h2);
      stamp_us = 32'h2;
      // all ones: clamp high, failsafe and lost set, timestamp at its top
      send_fixed_frame(8'hFF, 8'hFF, END_BYTE, 32'hFFFF_FFFF);
      // all zeros: clamp low, end byte by low nibble, period wraps
      send_fixed_frame(8'h00, 8'h00, 8'hA4, 32'h0000_0010);
      // bad end byte drops the frame, and the following start is not synced
      send_fixed_frame(8'h5A, 8'h08, 8'h55, 32'h0000_0200);
      send_byte(START_BYTE, next_stamp());
      await_idle();
   endtask

   task automatic test_limit_settings();
      logic [10:0] cfg [5][4];
      cfg[0] = '{11'd0, 11'h7FF, 11'd0, 11'h7FF};
      cfg[1] = '{11'h7FF, 11'd0, 11'h7FF, 11'd0};
      cfg[2] = '{11'd1000, 11'd1000, 11'd1000, 11'd1000};
      cfg[3] = '{11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom)};
      cfg[4] = '{CLAMP_MIN_RST, CLAMP_MAX_RST, LOW_LIMIT_RST, HIGH_LIMIT_RST};
      for (int k = 0; k < 5; k++) begin
         set_limits(cfg[k][0], cfg[k][1], cfg[k][2], cfg[k][3]);
         send_frame(1'b1);
      end
      await_idle();
   endtask

   // Receiver stalls while full-rate frames fill the frame queue.
   task automatic test_output_backpressure();
      await_idle();
      req_gap_max = 0;
      rsp_hold    = HOLD_CYCLES;
      for (int i = 0; i < 3; i++)
         send_frame(1'b1);
      req_gap_max = 8;
      await_idle();
   endtask

   task automatic test_random_traffic(input int item_count);
      int first;
      int pick;
      first = 0;
      while (first < item_count) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         pick = $urandom_range(0, 9);
         if (pick <= 6) begin
            send_frame(1'b1);
            first += 25;
         end else if (pick == 7) begin
            send_frame(1'b0);
            first += 25;
         end else begin
            send_noise($urandom_range(1, 5));
            first += 3;
         end
      end
      await_idle();
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = REG_CLAMP_MIN;
      csr_data       = '0;
      mismatch_count = 0;
      req_gap_max    = 8;
      rsp_gap_max    = 8;
      rsp_hold       = 0;
      stamp_us       = 32'h0;
      byte_pos       = 5'd0;
      prev_byte      = END_BYTE;
      lost_frames    = 32'h0;
      skipped_starts = 32'h0;
      bad_end_frames = 32'h0;
      last_frame_us  = 32'h0;
      clamp_lo       = CLAMP_MIN_RST;
      clamp_hi       = CLAMP_MAX_RST;
      low_lim        = LOW_LIMIT_RST;
      high_lim       = HIGH_LIMIT_RST;
      for (int i = 0; i < 24; i++)
         frame_bytes[i] = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frames();
      test_limit_settings();
      test_output_backpressure();
      test_random_traffic(50);

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
